[hdl/mpp_pkg.sv]
// mpp_pkg: shared types and constants of the note pattern playback unit
// item layouts, table entry packing, op and register codes, controller states
// no dependencies
package mpp_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int EVENT_BUDGET = 64;

    localparam int TAB_AW    = $clog2(TABLE_DEPTH);
    localparam int RP_W      = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W     = $clog2(EVENT_BUDGET + 1);
    localparam int NOTE_W    = 7;
    localparam int NUM_NOTES = 128;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP  = 2'd2;

    localparam logic [10:0] NOTE_COUNT_RST = 11'd0;
    localparam logic [15:0] LOOP_LEN_RST   = 16'd7680;
    localparam logic [23:0] TICK_STEP_RST  = 24'd5243;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_STOP   = 2'd2
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [9:0]  entry_index;
        logic [15:0] entry_tick;
        logic [6:0]  entry_note;
        logic [6:0]  entry_velocity;
        logic        entry_is_on;
        logic        entry_enabled;
    } t_in_item;

    typedef struct packed {
        logic       event_is_on;
        logic [6:0] event_note;
        logic [6:0] event_velocity;
        logic       last;
    } t_out_item;

    // one note table word
    typedef struct packed {
        logic        enabled;
        logic        is_on;
        logic [6:0]  velocity;
        logic [6:0]  note;
        logic [15:0] tick;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_WALK_RD,
        S_WALK_EV,
        S_WALK_ON,
        S_ADV,
        S_FINISH
    } t_state;

    // what follows an all-notes-off pass
    typedef enum logic {
        FL_PRE_WALK,
        FL_RESTART
    } t_flush_ctx;

endpackage

[hdl/mpp_in_if.sv]
// mpp_in_if: valid/ready channel carrying one input item
// depends on mpp_pkg
interface mpp_in_if;
    import mpp_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/mpp_out_if.sv]
// mpp_out_if: valid/ready channel carrying one note event item
// depends on mpp_pkg
interface mpp_out_if;
    import mpp_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/midi_pattern_playback_unit.sv]
// a load item is written to the note table when taken; a sample item runs any pending
// all-notes-off pass, walks the table (an off/on pair for a retriggered note), steps the
// position, with a pass on loop wrap; a stop item runs one pass; output stalls lengthen both
// throughput: one item at a time, set by the note table walk and the note scan
// reset: synchronous, active low; clears position, read pointer, sounding set and
// registers to their defaults; the note table is not cleared and holds junk until loaded
module midi_pattern_playback_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mpp_in_if.sink                         i_in_ch,
    mpp_out_if.source                      o_out_ch,
    input  logic                           i_cfg_we,
    input  logic [mpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mpp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mpp_pkg::*;

    // note table, written by load items and read by the walk, never both in the same cycle
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    logic              mem_we;
    logic              mem_re;
    logic [TAB_AW-1:0] mem_waddr;
    t_entry            mem_wdata;

    // configuration registers
    logic [10:0] r_note_count;
    logic [15:0] r_loop_len;
    logic [23:0] r_tick_step;

    // controller state
    t_state               r_state,    n_state;
    logic [RP_W-1:0]      r_rp,       n_rp;
    logic [31:0]          r_pos,      n_pos;
    logic                 r_pending,  n_pending;
    logic [NUM_NOTES-1:0] r_sounding, n_sounding;
    logic [CNT_W-1:0]     r_cnt,      n_cnt;
    logic [NOTE_W-1:0]    r_k,        n_k;
    t_flush_ctx           r_ctx,      n_ctx;

    // hold stage: the newest event waits here until we know whether it is the last
    t_out_item r_hold,       n_hold;
    logic      r_hold_valid, n_hold_valid;
    // output register
    t_out_item r_out,        n_out;
    logic      r_out_valid,  n_out_valid;

    logic            accept;
    logic            can_push;
    logic            stall;
    logic            emit_req;
    t_out_item       emit_ev;
    logic [RP_W-1:0] w_count;
    logic [32:0]     w_sum;
    logic [32:0]     w_end;
    logic            k_last;
    logic            cnt_full;

    assign i_in_ch.ready  = (r_state == S_IDLE);
    assign accept         = i_in_ch.valid && i_in_ch.ready;
    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

    // output register free this cycle, or being taken
    assign can_push = !r_out_valid || o_out_ch.ready;
    // a new event would have to shove the held one out
    assign stall    = r_hold_valid && !can_push;

    // entries beyond the table depth are never walked
    assign w_count  = (32'(r_note_count) > TABLE_DEPTH) ? RP_W'(TABLE_DEPTH)
                                                        : RP_W'(r_note_count);
    assign w_sum    = {1'b0, r_pos} + 33'(r_tick_step);
    assign w_end    = {1'b0, r_loop_len, 16'h0000};
    assign k_last   = (r_k == NOTE_W'(NUM_NOTES - 1));
    assign cnt_full = (r_cnt >= CNT_W'(EVENT_BUDGET));

    // table load port
    assign mem_we    = accept && (i_in_ch.data.op == OP_LOAD)
                       && (32'(i_in_ch.data.entry_index) < TABLE_DEPTH);
    assign mem_waddr = TAB_AW'(i_in_ch.data.entry_index);
    assign mem_wdata = '{enabled:  i_in_ch.data.entry_enabled,
                         is_on:    i_in_ch.data.entry_is_on,
                         velocity: i_in_ch.data.entry_velocity,
                         note:     i_in_ch.data.entry_note,
                         tick:     i_in_ch.data.entry_tick};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[r_rp[TAB_AW-1:0]];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_count <= NOTE_COUNT_RST;
            r_loop_len   <= LOOP_LEN_RST;
            r_tick_step  <= TICK_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NOTE_COUNT: r_note_count <= i_cfg_data[10:0];
                CFG_LOOP_LEN:   r_loop_len   <= i_cfg_data[15:0];
                CFG_TICK_STEP:  r_tick_step  <= i_cfg_data[23:0];
                default:        r_note_count <= r_note_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rp         <= '0;
            r_pos        <= '0;
            r_pending    <= 1'b0;
            r_sounding   <= '0;
            r_cnt        <= '0;
            r_k          <= '0;
            r_ctx        <= FL_PRE_WALK;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rp         <= n_rp;
            r_pos        <= n_pos;
            r_pending    <= n_pending;
            r_sounding   <= n_sounding;
            r_cnt        <= n_cnt;
            r_k          <= n_k;
            r_ctx        <= n_ctx;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_pos        = r_pos;
        n_pending    = r_pending;
        n_sounding   = r_sounding;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_ctx        = r_ctx;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        mem_re       = 1'b0;
        emit_req     = 1'b0;
        emit_ev      = '0;

        if (r_out_valid && o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_ch.data.op)
                        OP_SAMPLE: begin
                            n_cnt = '0;
                            if (r_pending) begin
                                // leftover note-offs go out before any table entry
                                n_k     = '0;
                                n_ctx   = FL_PRE_WALK;
                                n_state = S_FLUSH;
                            end else begin
                                n_state = S_WALK_RD;
                            end
                        end
                        OP_STOP: begin
                            n_cnt     = '0;
                            n_pos     = '0;
                            n_rp      = '0;
                            n_pending = 1'b1;
                            n_k       = '0;
                            n_ctx     = FL_RESTART;
                            n_state   = S_FLUSH;
                        end
                        default: begin
                            // loads go straight to the table, unknown ops do nothing
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // all-notes-off scan, one note number a cycle in ascending order while the output is not stalled
            S_FLUSH: begin
                if (r_sounding[r_k] && cnt_full) begin
                    // budget spent: the rest stays pending
                    n_state = (r_ctx == FL_RESTART) ? S_FINISH : S_ADV;
                end else if (r_sounding[r_k] && stall) begin
                    n_state = S_FLUSH;
                end else begin
                    if (r_sounding[r_k]) begin
                        emit_req             = 1'b1;
                        emit_ev.event_is_on  = 1'b0;
                        emit_ev.event_note   = r_k;
                        n_sounding[r_k]      = 1'b0;
                        n_cnt                = r_cnt + CNT_W'(1);
                    end
                    if (k_last) begin
                        n_pending = 1'b0;
                        n_state   = (r_ctx == FL_RESTART) ? S_FINISH : S_WALK_RD;
                    end else begin
                        n_k = r_k + NOTE_W'(1);
                    end
                end
            end

            S_WALK_RD: begin
                if ((r_rp < w_count) && !cnt_full) begin
                    mem_re  = 1'b1;
                    n_state = S_WALK_EV;
                end else begin
                    n_state = S_ADV;
                end
            end

            S_WALK_EV: begin
                if ({r_rd.tick, 16'h0000} > r_pos) begin
                    // entry lies in the future
                    n_state = S_ADV;
                end else if (!r_rd.enabled) begin
                    n_rp    = r_rp + RP_W'(1);
                    n_state = S_WALK_RD;
                end else if (!stall) begin
                    emit_req   = 1'b1;
                    emit_ev.event_note = r_rd.note;
                    n_cnt      = r_cnt + CNT_W'(1);
                    if (r_rd.is_on && r_sounding[r_rd.note]) begin
                        // retrigger: note-off first, then the note-on from S_WALK_ON
                        emit_ev.event_is_on    = 1'b0;
                        n_sounding[r_rd.note]  = 1'b0;
                        // one slot left: the note-on waits for the next sample
                        n_state = (r_cnt >= CNT_W'(EVENT_BUDGET - 1)) ? S_ADV : S_WALK_ON;
                    end else begin
                        emit_ev.event_is_on    = r_rd.is_on;
                        emit_ev.event_velocity = r_rd.is_on ? r_rd.velocity : 7'd0;
                        n_sounding[r_rd.note]  = r_rd.is_on;
                        n_rp                   = r_rp + RP_W'(1);
                        n_state                = S_WALK_RD;
                    end
                end
            end

            S_WALK_ON: begin
                if (!stall) begin
                    emit_req               = 1'b1;
                    emit_ev.event_is_on    = 1'b1;
                    emit_ev.event_note     = r_rd.note;
                    emit_ev.event_velocity = r_rd.velocity;
                    n_sounding[r_rd.note]  = 1'b1;
                    n_cnt                  = r_cnt + CNT_W'(1);
                    n_rp                   = r_rp + RP_W'(1);
                    n_state                = S_WALK_RD;
                end
            end

            // position step and loop wrap
            S_ADV: begin
                if (w_sum >= w_end) begin
                    n_pos     = '0;
                    n_rp      = '0;
                    n_pending = 1'b1;
                    n_k       = '0;
                    n_ctx     = FL_RESTART;
                    n_state   = S_FLUSH;
                end else begin
                    n_pos   = w_sum[31:0];
                    n_state = S_FINISH;
                end
            end

            // the held event is the item's last one
            S_FINISH: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (can_push) begin
                    n_out        = r_hold;
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new event pushes the held one to the output, not last
        if (emit_req) begin
            if (r_hold_valid) begin
                n_out       = r_hold;
                n_out.last  = 1'b0;
                n_out_valid = 1'b1;
            end
            n_hold       = emit_ev;
            n_hold_valid = 1'b1;
        end
    end

endmodule

[hdl/mpp_checker.sv]
// mpp_checker: port-level checks of the note pattern playback unit
// depends on mpp_pkg; bound to midi_pattern_playback_unit below
module mpp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input mpp_pkg::t_op       i_in_op,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input mpp_pkg::t_out_item i_out_data
);
    import mpp_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // after reset the block is empty and open for items
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not empty after reset");

    // a stalled event holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("event dropped or changed under stall");

    // loads and unknown ops finish in the cycle they are taken
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_op != OP_SAMPLE && i_in_op != OP_STOP) |=> i_in_ready)
        else $error("load item held the input");

    // samples and stops always keep the block busy for a while
    a_busy_after_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_op == OP_SAMPLE || i_in_op == OP_STOP)) |=> !i_in_ready)
        else $error("input reopened before item work");

endmodule

bind midi_pattern_playback_unit mpp_checker u_mpp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_op     (i_in_ch.data.op),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_data  (o_out_ch.data)
);
